>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the ray pick block.
// Needs nothing else; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define NPR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen outside reset
`define NPR_NEVER(label, clk, rst, cond, msg) \
  `NPR_ASSERT(label, clk, rst, !(cond), msg)

`endif

>>> hw/rtl/npr_pkg.sv
// Shared types and constants of the ray pick block.
// No dependencies; imported by every module of the block.
package npr_pkg;

  // Configuration register indexes
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ORIGIN_X = 3'd0;
  localparam reg_idx_t REG_ORIGIN_Y = 3'd1;
  localparam reg_idx_t REG_ORIGIN_Z = 3'd2;
  localparam reg_idx_t REG_DIR_X    = 3'd3;
  localparam reg_idx_t REG_DIR_Y    = 3'd4;
  localparam reg_idx_t REG_DIR_Z    = 3'd5;
  localparam reg_idx_t REG_THRESH   = 3'd6;

  // Bits of the multiplier operand consumed per cycle
  localparam int MUL_CHUNK = 16;

  // Distance engine states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ROOT  = 5'b01000,
    ST_DONE  = 5'b10000
  } dist_state_t;

  // Multiplier operand sources
  typedef enum logic [3:0] {
    SRC_DX, SRC_DY, SRC_DZ,
    SRC_FX, SRC_FY, SRC_FZ,
    SRC_CX, SRC_CY, SRC_CZ
  } src_sel_t;

  // Where the accumulator goes after an op
  typedef enum logic [2:0] {
    KEEP_NONE, KEEP_CX, KEEP_CY, KEEP_CZ, KEEP_C2, KEEP_D2
  } keep_sel_t;

  typedef struct packed {
    src_sel_t  a;
    src_sel_t  b;
    logic      neg;    // subtract product
    logic      first;  // clear accumulator first
    keep_sel_t keep;
  } mul_op_t;

  localparam int NUM_OPS = 12;
  typedef logic [3:0] op_idx_t;
  localparam op_idx_t LAST_OP = 4'(NUM_OPS - 1);

  // Cross product, its squared length, then squared direction length
  localparam mul_op_t OP_TABLE [NUM_OPS] = '{
    '{SRC_DY, SRC_FZ, 1'b0, 1'b1, KEEP_NONE},
    '{SRC_DZ, SRC_FY, 1'b1, 1'b0, KEEP_CX},
    '{SRC_DZ, SRC_FX, 1'b0, 1'b1, KEEP_NONE},
    '{SRC_DX, SRC_FZ, 1'b1, 1'b0, KEEP_CY},
    '{SRC_DX, SRC_FY, 1'b0, 1'b1, KEEP_NONE},
    '{SRC_DY, SRC_FX, 1'b1, 1'b0, KEEP_CZ},
    '{SRC_CX, SRC_CX, 1'b0, 1'b1, KEEP_NONE},
    '{SRC_CY, SRC_CY, 1'b0, 1'b0, KEEP_NONE},
    '{SRC_CZ, SRC_CZ, 1'b0, 1'b0, KEEP_C2},
    '{SRC_DX, SRC_DX, 1'b0, 1'b1, KEEP_NONE},
    '{SRC_DY, SRC_DY, 1'b0, 1'b0, KEEP_NONE},
    '{SRC_DZ, SRC_DZ, 1'b0, 1'b0, KEEP_D2}
  };

endpackage

>>> hw/rtl/npr_if.sv
// Stream interfaces of the ray pick block: points in, pick results out.
// No dependencies.
interface npr_point_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic                last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface npr_pick_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic                found;
  logic signed [W-1:0] picked_x;
  logic signed [W-1:0] picked_y;
  logic signed [W-1:0] picked_z;
  logic [W-1:0]        min_distance;
  modport source (output valid, found, picked_x, picked_y, picked_z, min_distance,
                  input ready);
  modport sink   (input valid, found, picked_x, picked_y, picked_z, min_distance,
                  output ready);
endinterface

>>> hw/rtl/npr_front.sv
// Front end: takes points, forms offsets from the ray origin, tags run end.
// Depends on npr_pkg and npr_point_if.
module npr_front #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  npr_point_if.sink           points,
  input  logic signed [W-1:0] origin_x,
  input  logic signed [W-1:0] origin_y,
  input  logic signed [W-1:0] origin_z,
  output logic                item_valid,
  input  logic                item_ready,
  output logic [6*W+3:0]      item_data
);
  import npr_pkg::*;

  logic signed [W:0] fx, fy, fz;

  assign points.ready = !item_valid || item_ready;

  // Offsets are one bit wider than the coordinates
  assign fx = {points.point_x[W-1], points.point_x} - {origin_x[W-1], origin_x};
  assign fy = {points.point_y[W-1], points.point_y} - {origin_y[W-1], origin_y};
  assign fz = {points.point_z[W-1], points.point_z} - {origin_z[W-1], origin_z};

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (points.ready) begin
      item_valid <= points.valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (points.valid && points.ready) begin
      item_data <= {points.last_point, points.point_x, points.point_y, points.point_z,
                    fx, fy, fz};
    end
  end
endmodule

>>> hw/rtl/npr_queue.sv
// Two-entry queue between the front end and the distance engine.
// Depends on npr_pkg.
module npr_queue #(
  parameter int DATA_W = 196
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);
  import npr_pkg::*;

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end
endmodule

>>> hw/rtl/npr_dist.sv
// Distance engine: exact floor(|d x f| / |d|) with a shared 16-bit-slice
// multiplier and a one-bit-per-cycle root search. Depends on npr_pkg.
module npr_dist #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [6*W+3:0]      in_data,
  input  logic signed [W-1:0] dir_x,
  input  logic signed [W-1:0] dir_y,
  input  logic signed [W-1:0] dir_z,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [W-1:0]        res_dist,
  output logic signed [W-1:0] res_px,
  output logic signed [W-1:0] res_py,
  output logic signed [W-1:0] res_pz,
  output logic                res_last
);
  import npr_pkg::*;

  localparam int OPW   = 2*W + 2;
  localparam int AW    = 2*W + 1;
  localparam int PPW   = AW + MUL_CHUNK;
  localparam int ACW   = 4*W + 3;
  localparam int C2W   = 4*W + 2;
  localparam int NSTEP = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int STW   = $clog2(NSTEP);
  localparam int BW    = $clog2(W);

  dist_state_t state;
  op_idx_t     op_idx;
  logic        mul_busy;
  logic        pp_valid;

  logic signed [W-1:0] pt_x, pt_y, pt_z;
  logic signed [W:0]   f_x, f_y, f_z;
  logic                last_q;

  logic [AW-1:0]  ma, mb;
  logic [STW-1:0] m_step;
  logic           m_neg, m_first;
  keep_sel_t      m_keep;

  logic [PPW-1:0] pp_val;
  logic [STW-1:0] pp_step;
  logic           pp_neg, pp_first;
  keep_sel_t      pp_keep;

  logic signed [ACW-1:0] acc;
  logic signed [OPW-1:0] cx, cy, cz;
  logic [C2W-1:0]        c2;
  logic [2*W-1:0]        d2;
  logic [ACW-1:0]        t_acc, us, ds;
  logic [W-1:0]          root;
  logic [BW-1:0]         bit_cnt;

  mul_op_t               cur_op;
  logic signed [OPW-1:0] opa, opb;
  logic [AW-1:0]         mag_a, mag_b;
  logic                  do_take, do_load, do_issue, chunk_last, root_init;
  logic [PPW-1:0]        pp_next;
  logic [ACW-1:0]        addend;
  logic signed [ACW-1:0] acc_base, acc_next;
  logic [ACW-1:0]        t_try;
  logic                  take_bit;

  function automatic logic signed [OPW-1:0] src_val(input src_sel_t s);
    logic signed [OPW-1:0] v;
    unique case (s)
      SRC_DX:  v = OPW'(dir_x);
      SRC_DY:  v = OPW'(dir_y);
      SRC_DZ:  v = OPW'(dir_z);
      SRC_FX:  v = OPW'(f_x);
      SRC_FY:  v = OPW'(f_y);
      SRC_FZ:  v = OPW'(f_z);
      SRC_CX:  v = cx;
      SRC_CY:  v = cy;
      SRC_CZ:  v = cz;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Operand fetch and magnitudes
  assign cur_op = OP_TABLE[op_idx];
  assign opa    = src_val(cur_op.a);
  assign opb    = src_val(cur_op.b);
  assign mag_a  = AW'(opa[OPW-1] ? -opa : opa);
  assign mag_b  = AW'(opb[OPW-1] ? -opb : opb);

  assign in_ready   = (state == ST_IDLE);
  assign do_take    = in_valid && in_ready;
  assign do_load    = (state == ST_MUL) && !mul_busy;
  assign do_issue   = (state == ST_MUL) && mul_busy;
  assign chunk_last = ((mb >> MUL_CHUNK) == '0);
  assign root_init  = (state == ST_DRAIN) && !pp_valid;

  // One slice of the product
  assign pp_next = PPW'(ma) * PPW'(mb[MUL_CHUNK-1:0]);

  // Accumulate the registered slice
  assign addend   = ACW'(pp_val) << (int'(pp_step) * MUL_CHUNK);
  assign acc_base = pp_first ? '0 : acc;
  assign acc_next = pp_neg ? (acc_base - $signed(addend)) : (acc_base + $signed(addend));

  // Root search trial: (r + 2^b)^2 * D2 against C2
  assign t_try    = t_acc + us + ds;
  assign take_bit = (t_try <= ACW'(c2));

  assign res_valid = (state == ST_DONE);
  assign res_dist  = root;
  assign res_px    = pt_x;
  assign res_py    = pt_y;
  assign res_pz    = pt_z;
  assign res_last  = last_q;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      op_idx   <= '0;
      mul_busy <= 1'b0;
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= do_issue;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_MUL;
            op_idx   <= '0;
            mul_busy <= 1'b0;
          end
        end
        ST_MUL: begin
          if (!mul_busy) begin
            mul_busy <= 1'b1;
          end else if (chunk_last) begin
            mul_busy <= 1'b0;
            if (op_idx == LAST_OP) state <= ST_DRAIN;
            else op_idx <= op_idx + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (!pp_valid) state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (bit_cnt == '0) state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (do_take) begin
      last_q <= in_data[6*W+3];
      pt_x   <= in_data[6*W+2 -: W];
      pt_y   <= in_data[5*W+2 -: W];
      pt_z   <= in_data[4*W+2 -: W];
      f_x    <= in_data[3*W+2 -: W+1];
      f_y    <= in_data[2*W+1 -: W+1];
      f_z    <= in_data[W -: W+1];
    end
    if (do_load) begin
      ma      <= mag_a;
      mb      <= mag_b;
      m_step  <= '0;
      m_neg   <= opa[OPW-1] ^ opb[OPW-1] ^ cur_op.neg;
      m_first <= cur_op.first;
      m_keep  <= cur_op.keep;
    end
    if (do_issue) begin
      pp_val   <= pp_next;
      pp_step  <= m_step;
      pp_neg   <= m_neg;
      pp_first <= m_first;
      pp_keep  <= chunk_last ? m_keep : KEEP_NONE;
      m_first  <= 1'b0;
      mb       <= mb >> MUL_CHUNK;
      m_step   <= m_step + STW'(1);
    end
    if (pp_valid) begin
      acc <= acc_next;
      unique case (pp_keep)
        KEEP_CX:   cx <= acc_next[OPW-1:0];
        KEEP_CY:   cy <= acc_next[OPW-1:0];
        KEEP_CZ:   cz <= acc_next[OPW-1:0];
        KEEP_C2:   c2 <= acc_next[C2W-1:0];
        KEEP_D2:   d2 <= acc_next[2*W-1:0];
        default:   ;
      endcase
    end
    if (root_init) begin
      t_acc   <= '0;
      us      <= '0;
      ds      <= ACW'(d2) << (2*W - 2);
      root    <= '0;
      bit_cnt <= BW'(W - 1);
    end else if (state == ST_ROOT) begin
      if (take_bit) begin
        t_acc         <= t_try;
        us            <= (us + (ds << 1)) >> 1;
        root[bit_cnt] <= 1'b1;
      end else begin
        us <= us >> 1;
      end
      ds      <= ds >> 2;
      bit_cnt <= bit_cnt - BW'(1);
    end
  end
endmodule

>>> hw/rtl/nearest_point_to_ray_pick.sv
// Nearest point to ray pick. Each point goes through a front stage and a
// two-entry queue, then an exact distance engine: twelve products on one
// shared multiplier that takes 16 operand bits a cycle once the operands
// of a product are loaded (one 16-bit slice of the second operand at a time,
// up to its highest nonzero slice, at least one), a drain of the last slice,
// then a root search of one bit per cycle, a result held until it is taken
// and a return to idle before the next point is taken. A last point yields
// one transfer on picks; other points yield none.
`include "assert_macros.svh"

module nearest_point_to_ray_pick #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  npr_point_if.sink              points,
  npr_pick_if.source             picks,
  input  logic                   cfg_we,
  input  npr_pkg::reg_idx_t      cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);
  import npr_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int ITEM_W = 6*W + 4;

  logic signed [W-1:0] origin_x, origin_y, origin_z;
  logic signed [W-1:0] dir_x, dir_y, dir_z;
  logic [W-1:0]        threshold;

  logic              item_valid, item_ready;
  logic [ITEM_W-1:0] item_data;
  logic              q_valid, q_ready;
  logic [ITEM_W-1:0] q_data;

  logic                res_valid, res_ready, res_last;
  logic [W-1:0]        res_dist;
  logic signed [W-1:0] res_px, res_py, res_pz;
  logic                res_fire, lower, pick;

  logic [W-1:0]        run_min, run_min_next;
  logic                found_flag, found_next;
  logic signed [W-1:0] best_x, best_y, best_z;
  logic                pick_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      dir_x     <= '0;
      dir_y     <= '0;
      dir_z     <= W'(65536);
      threshold <= W'(19661);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x  <= cfg_data;
        REG_ORIGIN_Y: origin_y  <= cfg_data;
        REG_ORIGIN_Z: origin_z  <= cfg_data;
        REG_DIR_X:    dir_x     <= cfg_data;
        REG_DIR_Y:    dir_y     <= cfg_data;
        REG_DIR_Z:    dir_z     <= cfg_data;
        REG_THRESH:   threshold <= cfg_data;
        default:      ;
      endcase
    end
  end

  npr_front #(.W(W)) u_front (
    .clk        (clk),
    .rst        (rst),
    .points     (points),
    .origin_x   (origin_x),
    .origin_y   (origin_y),
    .origin_z   (origin_z),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_data  (item_data)
  );

  npr_queue #(.DATA_W(ITEM_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_data   (item_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  npr_dist #(.W(W)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_dist  (res_dist),
    .res_px    (res_px),
    .res_py    (res_py),
    .res_pz    (res_pz),
    .res_last  (res_last)
  );

  // Running minimum and pick decision
  assign res_ready    = !pick_valid || picks.ready;
  assign res_fire     = res_valid && res_ready;
  assign lower        = (res_dist < run_min);
  assign pick         = lower && (res_dist < threshold);
  assign run_min_next = lower ? res_dist : run_min;
  assign found_next   = found_flag || pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min    <= '1;
      found_flag <= 1'b0;
      best_x     <= '0;
      best_y     <= '0;
      best_z     <= '0;
    end else if (res_fire) begin
      run_min    <= res_last ? '1 : run_min_next;
      found_flag <= found_next;
      if (pick) begin
        best_x <= res_px;
        best_y <= res_py;
        best_z <= res_pz;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_valid <= 1'b0;
    end else if (res_fire && res_last) begin
      pick_valid <= 1'b1;
    end else if (picks.ready) begin
      pick_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire && res_last) begin
      picks.found        <= found_next;
      picks.picked_x     <= pick ? res_px : best_x;
      picks.picked_y     <= pick ? res_py : best_y;
      picks.picked_z     <= pick ? res_pz : best_z;
      picks.min_distance <= run_min_next;
    end
  end

  assign picks.valid = pick_valid;

  // Checks
  `NPR_ASSERT(a_found_sticky, clk, rst, found_flag |=> found_flag, "found flag cleared")
  `NPR_ASSERT(a_run_restart, clk, rst, (res_fire && res_last) |=> (run_min == '1),
              "run minimum not restored after run end")
  `NPR_ASSERT(a_pick_source, clk, rst, $rose(pick_valid) |-> $past(res_fire && res_last),
              "result raised without a run end")
endmodule

>>> verif/nearest_point_to_ray_pick_test.sv
// Testbench for the nearest point to ray pick block: drives point runs, sets
// the ray registers between runs and checks every pick result.
// Depends on npr_pkg, npr_if.sv and nearest_point_to_ray_pick.sv.
`timescale 1ns / 1ps

module nearest_point_to_ray_pick_test;
  import npr_pkg::*;

  localparam int CW = 32;
  localparam int SETTLE_CYCLES = 500;  // idle time after the last pick arrives
  localparam int SHOWN_ERRORS = 10;
  localparam reg_idx_t REG_UNUSED = 3'd7;
  localparam logic [CW-1:0] DIST_MAX = '1;
  localparam logic [CW-1:0] ONE = 32'd65536;

  typedef struct {
    logic          found;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [CW-1:0] pz;
    logic [CW-1:0] min_dist;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_ORIGIN_X;
  logic [CW-1:0] cfg_data = '0;

  npr_point_if #(CW) points_ch ();
  npr_pick_if #(CW) picks_ch ();

  nearest_point_to_ray_pick #(.COORD_WIDTH(CW)) dut (
    .clk(clk),
    .rst(rst),
    .points(points_ch),
    .picks(picks_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the ray registers and pick state
  logic [CW-1:0] org_x, org_y, org_z, dir_x, dir_y, dir_z, thresh;
  logic [CW-1:0] run_min, best_x, best_y, best_z;
  logic          found_flag;
  pick_t         pending_picks[$];
  int            mismatches = 0;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;

  // Exact perpendicular distance, floor(sqrt(|d x f|^2 / |d|^2)), saturating
  function automatic logic [CW-1:0] ray_dist(logic [CW-1:0] px, logic [CW-1:0] py,
                                             logic [CW-1:0] pz);
    logic signed [255:0] dx, dy, dz, fx, fy, fz, cx, cy, cz;
    logic [255:0] c2, d2, cand;
    logic [CW-1:0] r;
    dx = $signed(dir_x);
    dy = $signed(dir_y);
    dz = $signed(dir_z);
    fx = 256'($signed(px)) - 256'($signed(org_x));
    fy = 256'($signed(py)) - 256'($signed(org_y));
    fz = 256'($signed(pz)) - 256'($signed(org_z));
    cx = dy * fz - dz * fy;
    cy = dz * fx - dx * fz;
    cz = dx * fy - dy * fx;
    c2 = cx * cx + cy * cy + cz * cz;
    d2 = dx * dx + dy * dy + dz * dz;
    r = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      cand = 256'(r | (CW'(1) << b));
      if (cand * cand * d2 <= c2) r = CW'(cand);
    end
    return r;
  endfunction

  // Update the pick state for one accepted point
  task automatic track_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                             logic last);
    logic [CW-1:0] d;
    pick_t p;
    d = ray_dist(px, py, pz);
    if (d < run_min) begin
      run_min = d;
      if (d < thresh) begin
        best_x = px;
        best_y = py;
        best_z = pz;
        found_flag = 1'b1;
      end
    end
    if (last) begin
      p.found = found_flag;
      p.px = best_x;
      p.py = best_y;
      p.pz = best_z;
      p.min_dist = run_min;
      pending_picks.push_back(p);
      run_min = DIST_MAX;
    end
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ORIGIN_X: org_x = val;
      REG_ORIGIN_Y: org_y = val;
      REG_ORIGIN_Z: org_z = val;
      REG_DIR_X:    dir_x = val;
      REG_DIR_Y:    dir_y = val;
      REG_DIR_Z:    dir_z = val;
      REG_THRESH:   thresh = val;
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                         logic [CW-1:0] dx, logic [CW-1:0] dy, logic [CW-1:0] dz,
                         logic [CW-1:0] th);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
    write_reg(REG_THRESH, th);
  endtask

  // One point transfer; valid stays high into the next call unless a gap is rolled
  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                            logic last);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(negedge clk);
    end
    points_ch.valid <= 1'b1;
    points_ch.point_x <= px;
    points_ch.point_y <= py;
    points_ch.point_z <= pz;
    points_ch.last_point <= last;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    track_point(px, py, pz, last);
  endtask

  // Stop sending, let all picks arrive and the engine go quiet
  task automatic drain();
    @(negedge clk);
    points_ch.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) picks_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

  // Result checker
  always @(posedge clk) begin
    if (!rst && picks_ch.valid && picks_ch.ready) begin
      if (pending_picks.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) $display("unexpected pick transfer at %0t", $time);
      end else begin
        pick_t e;
        e = pending_picks.pop_front();
        if (picks_ch.found !== e.found || picks_ch.picked_x !== e.px ||
            picks_ch.picked_y !== e.py || picks_ch.picked_z !== e.pz ||
            picks_ch.min_distance !== e.min_dist) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("pick mismatch at %0t: exp %b %h %h %h %h got %b %h %h %h %h", $time,
                     e.found, e.px, e.py, e.pz, e.min_dist, picks_ch.found,
                     picks_ch.picked_x, picks_ch.picked_y, picks_ch.picked_z,
                     picks_ch.min_distance);
        end
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return CW'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      default: return CW'($signed($urandom_range(65536)) - 32768);
    endcase
  endfunction

  // Default ray (origin at zero, along z, threshold 0.3)
  task automatic test_reset_defaults();
    send_point(32'd0, 32'd0, 32'd0, 1'b0);
    send_point(32'd65536, 32'd0, 32'd0, 1'b1);
    send_point(32'd20000, 32'd0, 32'd5, 1'b1);   // above threshold, keeps old pick
    send_point(32'd3000, 32'hFFFF_F000, 32'h7FFF_FFFF, 1'b1);
    drain();
  endtask

  // Extreme coordinates, zero direction, equal distances, threshold limits
  task automatic test_extremes();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);        // ignored
    set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, DIST_MAX);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_point(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
    drain();
    // zero direction: saturated distance, never picked
    set_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, DIST_MAX);
    send_point(32'd1, 32'd2, 32'd3, 1'b1);
    drain();
    // threshold zero: nothing picked; repeated point gives equal distance
    set_ray(32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0);
    send_point(32'd5, ONE, 32'd0, 1'b0);
    send_point(32'd5, ONE, 32'd0, 1'b0);
    send_point(32'd0, 32'd0, 32'd0, 1'b1);
    drain();
    write_reg(REG_THRESH, ONE * 2);
    send_point(32'd9, ONE, 32'd0, 1'b0);
    send_point(32'd7, ONE, 32'd0, 1'b1);         // equal distance, first one kept
    drain();
  endtask

  // Random runs around a random ray
  task automatic test_random(int idle, int stall, int items, bit hold_off);
    int sent;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    set_ray(rand_coord(), rand_coord(), rand_coord(),
            ($urandom_range(4) == 0) ? 32'($urandom) : rand_coord(),
            rand_coord(), rand_coord(),
            ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(4 * 65536)));
    sent = 0;
    while (sent < items) begin
      int len;
      len = $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
        sent++;
      end
      if (hold_off && sent > items / 2) begin
        hold_off = 0;
        @(negedge clk);
        points_ch.valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    org_x = '0; org_y = '0; org_z = '0;
    dir_x = '0; dir_y = '0; dir_z = ONE;
    thresh = 32'd19661;
    run_min = DIST_MAX;
    found_flag = 1'b0;
    best_x = '0; best_y = '0; best_z = '0;
    points_ch.valid = 1'b0;
    points_ch.point_x = '0;
    points_ch.point_y = '0;
    points_ch.point_z = '0;
    points_ch.last_point = 1'b0;
    picks_ch.ready = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extremes();
    test_random(0, 0, 100, 1'b1);
    test_random(60, 0, 100, 1'b0);
    test_random(0, 60, 100, 1'b0);
    test_random(24, 24, 100, 1'b0);

    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/npr_pkg.sv
hw/rtl/npr_if.sv
hw/rtl/npr_front.sv
hw/rtl/npr_queue.sv
hw/rtl/npr_dist.sv
hw/rtl/nearest_point_to_ray_pick.sv
verif/nearest_point_to_ray_pick_test.sv
